@@ rtl/cbd_pkg.sv @@
// ----------------------------------------------------------------------------
// cbd_pkg
// Types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int MAX_BODY  = 1048576;
    localparam int SIZE_BITS = 32;
    localparam int LEN_W     = 21;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BODY);

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_EXT   = 3'd1,
        PH_DATA  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_STOP  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             byte_present;
        logic             body_done;
        logic [LEN_W-1:0] decoded_length;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            h.value = 4'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.value = 4'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.value = 4'(c - CH_UA + 8'd10);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ rtl/cbd_core.sv @@
// ----------------------------------------------------------------------------
// cbd_core
// Decode state and per-byte next-state logic; result is combinational.
// ----------------------------------------------------------------------------
module cbd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_res_valid,
    output cbd_pkg::t_result      o_res
);

    cbd_pkg::t_phase                r_phase, n_phase;
    logic [cbd_pkg::SIZE_BITS-1:0]  r_count, n_count;
    logic                           r_saw, n_saw;
    logic [cbd_pkg::LEN_W-1:0]      r_emit, n_emit;

    cbd_pkg::t_hex                  hx;
    logic                           present;
    logic [cbd_pkg::SIZE_BITS-1:0]  count_dec;

    assign hx        = cbd_pkg::hex_decode(i_byte);
    assign count_dec = r_count - cbd_pkg::SIZE_BITS'(1);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_saw   = r_saw;
        present = 1'b0;
        case (r_phase)
            cbd_pkg::PH_SIZE: begin
                if (hx.is_hex) begin
                    n_count = {r_count[cbd_pkg::SIZE_BITS-5:0], hx.value};
                    n_saw   = 1'b1;
                end else if (!r_saw) begin
                    n_phase = cbd_pkg::PH_STOP;
                end else if (i_byte == cbd_pkg::CH_NL) begin
                    n_phase = (r_count == '0) ? cbd_pkg::PH_STOP : cbd_pkg::PH_DATA;
                end else begin
                    n_phase = cbd_pkg::PH_EXT;
                end
            end
            cbd_pkg::PH_EXT: begin
                if (i_byte == cbd_pkg::CH_NL) begin
                    n_phase = (r_count == '0) ? cbd_pkg::PH_STOP : cbd_pkg::PH_DATA;
                end
            end
            cbd_pkg::PH_DATA: begin
                present = 1'b1;
                n_count = count_dec;
                if (count_dec == '0) begin
                    n_phase = cbd_pkg::PH_TRAIL;
                end
            end
            cbd_pkg::PH_TRAIL: begin
                // new size line starts from a clean count
                if (i_byte != cbd_pkg::CH_CR && i_byte != cbd_pkg::CH_NL) begin
                    if (hx.is_hex) begin
                        n_phase = cbd_pkg::PH_SIZE;
                        n_count = cbd_pkg::SIZE_BITS'(hx.value);
                        n_saw   = 1'b1;
                    end else begin
                        n_phase = cbd_pkg::PH_STOP;
                        n_count = '0;
                        n_saw   = 1'b0;
                    end
                end
            end
            default: begin
                n_phase = cbd_pkg::PH_STOP;
            end
        endcase
    end

    always_comb begin
        n_emit = r_emit;
        if (present && r_emit < cbd_pkg::LEN_MAX) begin
            n_emit = r_emit + cbd_pkg::LEN_W'(1);
        end
    end

    always_comb begin
        o_res_valid          = i_accept && (present || i_last);
        o_res.payload_byte   = present ? i_byte : 8'd0;
        o_res.byte_present   = present;
        o_res.body_done      = i_last;
        o_res.decoded_length = n_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cbd_pkg::PH_SIZE;
            r_count <= '0;
            r_saw   <= 1'b0;
            r_emit  <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_phase <= cbd_pkg::PH_SIZE;
                r_count <= '0;
                r_saw   <= 1'b0;
                r_emit  <= '0;
            end else begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_saw   <= n_saw;
                r_emit  <= n_emit;
            end
        end
    end

endmodule

@@ rtl/chunked_body_decoder_top.sv @@
// ----------------------------------------------------------------------------
// chunked_body_decoder_top
// Chunked transfer body decoder with stream ports and a skid-buffered output.
// ----------------------------------------------------------------------------
// One body byte is taken per clock while o_s_tready is high and decoded by the
// phase/size update in the cycle it arrives; its result word, if any, is registered
// in the output register, or in the skid register while a stalled sink holds that
// one. A word comes out for every payload byte and for the byte marked last. The
// two-deep output buffer keeps input flowing for one extra word while the sink stalls.
module chunked_body_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] body_byte
    input  logic        i_s_tlast,   // body_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] payload_byte, [28:8] decoded_length
    output logic        o_m_tuser,   // byte_present
    output logic        o_m_tlast    // body_done
);

    logic             accept;
    logic             res_valid;
    cbd_pkg::t_result res;

    logic             r_out_valid, r_skid_valid;
    cbd_pkg::t_result r_out, r_skid;
    logic             out_fire;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_fire   = r_out_valid && i_m_tready;

    cbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire && r_skid_valid) begin
            r_out        <= r_skid;
            r_skid_valid <= 1'b0;
        end else if (res_valid && (!r_out_valid || out_fire)) begin
            r_out       <= res;
            r_out_valid <= 1'b1;
        end else if (res_valid) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.decoded_length, r_out.payload_byte};
    assign o_m_tuser  = r_out.byte_present;
    assign o_m_tlast  = r_out.body_done;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tlast) |=> o_m_tvalid)
        else $error("last byte produced no output word");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.decoded_length <= cbd_pkg::LEN_MAX))
        else $error("decoded length beyond maximum");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_tready) |=> r_skid_valid)
        else $error("skid word lost while sink stalled");

endmodule
